// ===== rtl/core/wireframe_edge_transform_clip_assert.svh =====
// assertion macros for the wireframe edge transform and clip block
// no dependencies; included by files that carry concurrent checks
`ifndef WIREFRAME_EDGE_TRANSFORM_CLIP_ASSERT_SVH
`define WIREFRAME_EDGE_TRANSFORM_CLIP_ASSERT_SVH
`ifndef ASSERT_OFF
`define WETC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("wetc check failed");
`define WETC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("wetc forbidden condition");
`else
`define WETC_ASSERT(lbl, clk, rst_n, prop)
`define WETC_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== rtl/core/wetc_pkg.sv =====
// shared types, constants and helpers of the edge transform and clip block
// no dependencies
package wetc_pkg;

	// near plane z = 0.1 and 1.0 in q16.16
	localparam logic signed [31:0] NEAR_Q = 32'sd6554;
	localparam logic signed [31:0] ONE_Q  = 32'sd65536;

	// quotient bits of the clip factor and projection dividers
	localparam int CLIP_Q_W = 31;
	localparam int PROJ_Q_W = 36;

	// pipeline depth of each part
	localparam int LANE_LAT = 4;
	localparam int CLIP_LAT = CLIP_Q_W + 3;
	localparam int PROJ_LAT = PROJ_Q_W + 3;

	typedef enum logic [2:0] {
		REG_SPIN_COS   = 3'd0,
		REG_SPIN_SIN   = 3'd1,
		REG_PUSH_DEPTH = 3'd2,
		REG_CAM_X      = 3'd3,
		REG_CAM_Y      = 3'd4,
		REG_CAM_Z      = 3'd5,
		REG_YAW_COS    = 3'd6,
		REG_YAW_SIN    = 3'd7
	} wetc_reg_t;

	typedef struct packed {
		logic signed [15:0] spin_cos;
		logic signed [15:0] spin_sin;
		logic signed [31:0] push_depth;
		logic signed [31:0] cam_x;
		logic signed [31:0] cam_y;
		logic signed [31:0] cam_z;
		logic signed [15:0] yaw_cos;
		logic signed [15:0] yaw_sin;
	} wetc_cfg_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} wetc_vtx_t;

	// clamp to the signed 32 bit range
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/wetc_div.sv =====
// pipelined unsigned restoring divider, one quotient bit per stage
// depends on nothing; the upper dividend bits must be below the divisor
module wetc_div #(
	parameter int NUM_W  = 62,
	parameter int DEN_W  = 32,
	parameter int Q_W    = 31,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  dividend,
	input  logic [DEN_W-1:0]  divisor,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [Q_W-1:0]    quotient,
	output logic [SIDE_W-1:0] out_side
);

	logic [Q_W-1:0]    v_q;
	logic [DEN_W-1:0]  rem_q [Q_W];
	logic [DEN_W-1:0]  rem_d [Q_W];
	logic [DEN_W-1:0]  d_q   [Q_W];
	logic [Q_W-1:0]    lo_q  [Q_W];
	logic [Q_W-1:0]    lo_d  [Q_W];
	logic [Q_W-1:0]    q_q   [Q_W];
	logic [Q_W-1:0]    q_d   [Q_W];
	logic [SIDE_W-1:0] s_q   [Q_W];

	// one trial subtract per stage
	always_comb begin
		logic [DEN_W-1:0] rp;
		logic [DEN_W-1:0] dp;
		logic [Q_W-1:0]   lp;
		logic [Q_W-1:0]   qp;
		logic [DEN_W:0]   cur;
		logic             take;
		for (int k = 0; k < Q_W; k++) begin
			if (k == 0) begin
				rp = DEN_W'(dividend[NUM_W-1:Q_W]);
				lp = dividend[Q_W-1:0];
				qp = '0;
				dp = divisor;
			end else begin
				rp = rem_q[k-1];
				lp = lo_q[k-1];
				qp = q_q[k-1];
				dp = d_q[k-1];
			end
			cur      = {rp, lp[Q_W-1]};
			take     = cur >= {1'b0, dp};
			rem_d[k] = take ? DEN_W'(cur - {1'b0, dp}) : cur[DEN_W-1:0];
			lo_d[k]  = lp << 1;
			q_d[k]   = {qp[Q_W-2:0], take};
		end
	end

	// transaction valid travels with the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[Q_W-2:0], in_valid};
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		for (int k = 0; k < Q_W; k++) begin
			rem_q[k] <= rem_d[k];
			lo_q[k]  <= lo_d[k];
			q_q[k]   <= q_d[k];
			if (k == 0) begin
				d_q[k] <= divisor;
				s_q[k] <= in_side;
			end else begin
				d_q[k] <= d_q[k-1];
				s_q[k] <= s_q[k-1];
			end
		end
	end

	assign out_valid = v_q[Q_W-1];
	assign quotient  = q_q[Q_W-1];
	assign out_side  = s_q[Q_W-1];

endmodule

// ===== rtl/core/wetc_lane.sv =====
// one vertex lane: model spin, push, camera offset and camera yaw
// depends on wetc_pkg
module wetc_lane import wetc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  wetc_vtx_t in_vtx,
	input  wetc_cfg_t cfg,
	output logic      out_valid,
	output wetc_vtx_t out_vtx
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [47:0] mxc_s1, mzs_s1, mxs_s1, mzc_s1;
	logic signed [31:0] y_s1;
	logic signed [35:0] x_s2;
	logic signed [32:0] y_s2;
	logic signed [36:0] z_s2;
	logic signed [52:0] pxc_s3, pzs_s3, pxs_s3, pzc_s3;
	logic signed [32:0] y_s3;
	wetc_vtx_t vtx_s4;

	logic signed [48:0] sx_d, sz_d;
	logic signed [34:0] xr_d, zr_d;
	logic signed [53:0] ex_d, ez_d;
	logic signed [39:0] er_x_d, er_z_d;

	// spin sums and floor shift, feeding the offset stage
	always_comb begin
		sx_d = 49'(mxc_s1) - 49'(mzs_s1);
		sz_d = 49'(mxs_s1) + 49'(mzc_s1);
		xr_d = sx_d[48:14];
		zr_d = sz_d[48:14];
	end

	// yaw sums and floor shift
	always_comb begin
		ex_d   = 54'(pxc_s3) - 54'(pzs_s3);
		ez_d   = 54'(pxs_s3) + 54'(pzc_s3);
		er_x_d = ex_d[53:14];
		er_z_d = ez_d[53:14];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		mxc_s1 <= 48'(in_vtx.x) * 48'(cfg.spin_cos);
		mzs_s1 <= 48'(in_vtx.z) * 48'(cfg.spin_sin);
		mxs_s1 <= 48'(in_vtx.x) * 48'(cfg.spin_sin);
		mzc_s1 <= 48'(in_vtx.z) * 48'(cfg.spin_cos);
		y_s1   <= in_vtx.y;

		x_s2 <= 36'(xr_d) - 36'(cfg.cam_x);
		y_s2 <= 33'(y_s1) - 33'(cfg.cam_y);
		z_s2 <= 37'(zr_d) + 37'(cfg.push_depth) - 37'(cfg.cam_z);

		pxc_s3 <= 53'(x_s2) * 53'(cfg.yaw_cos);
		pzs_s3 <= 53'(z_s2) * 53'(cfg.yaw_sin);
		pxs_s3 <= 53'(x_s2) * 53'(cfg.yaw_sin);
		pzc_s3 <= 53'(z_s2) * 53'(cfg.yaw_cos);
		y_s3   <= y_s2;

		vtx_s4.x <= sat32(64'(er_x_d));
		vtx_s4.y <= sat32(64'(y_s3));
		vtx_s4.z <= sat32(64'(er_z_d));
	end

	assign out_valid = v_s4;
	assign out_vtx   = vtx_s4;

endmodule

// ===== rtl/core/wetc_clip.sv =====
// merging stage: near plane test and clip of the endpoint behind it
// depends on wetc_pkg and wetc_div
module wetc_clip import wetc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  wetc_vtx_t in_a,
	input  wetc_vtx_t in_b,
	output logic      out_valid,
	output logic      out_vis,
	output wetc_vtx_t out_a,
	output wetc_vtx_t out_b
);

	typedef struct packed {
		logic               a_beh;
		logic               b_beh;
		wetc_vtx_t          a;
		wetc_vtx_t          b;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
	} clip_side_t;

	logic       v_s1;
	clip_side_t side_s1;
	logic [31:0] num_s1, den_s1;

	logic                dv_valid;
	logic [CLIP_Q_W-1:0] dv_t;
	clip_side_t          dv_side;

	logic               v_s2;
	clip_side_t         side_s2;
	logic signed [63:0] px_s2, py_s2;

	logic       v_s3, vis_s3;
	wetc_vtx_t  a_s3, b_s3;

	logic a_beh_d, b_beh_d;
	wetc_vtx_t m_d, o_d;
	logic signed [32:0] num_d, den_d;
	logic signed [31:0] t_d;
	logic signed [33:0] shx_d, shy_d;
	wetc_vtx_t a_o_d, b_o_d;

	// pick the endpoint to move and the clip fraction terms
	always_comb begin
		a_beh_d = in_a.z < NEAR_Q;
		b_beh_d = in_b.z < NEAR_Q;
		if (a_beh_d) begin
			m_d = in_a;
			o_d = in_b;
		end else begin
			m_d = in_b;
			o_d = in_a;
		end
		num_d = 33'(NEAR_Q) - 33'(m_d.z);
		den_d = 33'(o_d.z) - 33'(m_d.z);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= dv_valid;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.a_beh <= a_beh_d;
		side_s1.b_beh <= b_beh_d;
		side_s1.a     <= in_a;
		side_s1.b     <= in_b;
		side_s1.dx    <= 33'(o_d.x) - 33'(m_d.x);
		side_s1.dy    <= 33'(o_d.y) - 33'(m_d.y);
		num_s1        <= num_d[31:0];
		den_s1        <= den_d[31:0];
	end

	// t = (near - zin) * 2^30 / (zout - zin)
	wetc_div #(
		.NUM_W (32 + 30),
		.DEN_W (32),
		.Q_W   (CLIP_Q_W),
		.SIDE_W($bits(clip_side_t))
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.dividend ({num_s1, 30'd0}),
		.divisor  (den_s1),
		.in_side  (side_s1),
		.out_valid(dv_valid),
		.quotient (dv_t),
		.out_side (dv_side)
	);

	assign t_d = {1'b0, dv_t};

	// scale the edge deltas by t
	always_ff @(posedge clk) begin
		side_s2 <= dv_side;
		px_s2   <= 64'(dv_side.dx) * 64'(t_d);
		py_s2   <= 64'(dv_side.dy) * 64'(t_d);
	end

	// move the endpoint behind the plane onto it
	always_comb begin
		shx_d = px_s2[63:30];
		shy_d = py_s2[63:30];
		a_o_d = side_s2.a;
		b_o_d = side_s2.b;
		if (side_s2.a_beh && !side_s2.b_beh) begin
			a_o_d.x = 32'(34'(side_s2.a.x) + shx_d);
			a_o_d.y = 32'(34'(side_s2.a.y) + shy_d);
			a_o_d.z = NEAR_Q;
		end else if (side_s2.b_beh && !side_s2.a_beh) begin
			b_o_d.x = 32'(34'(side_s2.b.x) + shx_d);
			b_o_d.y = 32'(34'(side_s2.b.y) + shy_d);
			b_o_d.z = NEAR_Q;
		end
	end

	always_ff @(posedge clk) begin
		vis_s3 <= !(side_s2.a_beh && side_s2.b_beh);
		a_s3   <= a_o_d;
		b_s3   <= b_o_d;
	end

	assign out_valid = v_s3;
	assign out_vis   = vis_s3;
	assign out_a     = a_s3;
	assign out_b     = b_s3;

endmodule

// ===== rtl/core/wetc_proj.sv =====
// one projected coordinate: coord / z and mapping to screen pixels
// depends on wetc_pkg and wetc_div
module wetc_proj import wetc_pkg::*; #(
	parameter int SCREEN = 800,
	parameter bit IS_Y   = 1'b0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_keep,
	input  logic signed [31:0] coord,
	input  logic signed [31:0] depth,
	output logic               out_valid,
	output logic               out_keep,
	output logic signed [31:0] pix
);

	localparam int N_W = PROJ_Q_W + 2;
	localparam int PW  = N_W + $clog2(SCREEN + 1);

	logic        v_s1, neg_s1, keep_s1;
	logic [31:0] mag_s1, den_s1;

	logic                dv_valid;
	logic [PROJ_Q_W-1:0] dv_q;
	logic [1:0]          dv_side;

	logic                v_s2, keep_s2;
	logic signed [PW-1:0] prod_s2;

	logic                v_s3, keep_s3;
	logic signed [31:0]  pix_s3;

	logic signed [N_W-1:0] qs_d, n_d, v_d;
	logic signed [PW-2:0]  half_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= dv_valid;
			v_s3 <= v_s2;
		end
	end

	// magnitude for a quotient truncated toward zero
	always_ff @(posedge clk) begin
		neg_s1  <= coord[31];
		keep_s1 <= in_keep;
		mag_s1  <= coord[31] ? (~coord + 32'd1) : coord;
		den_s1  <= depth;
	end

	wetc_div #(
		.NUM_W (32 + 16),
		.DEN_W (32),
		.Q_W   (PROJ_Q_W),
		.SIDE_W(2)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.dividend ({mag_s1, 16'd0}),
		.divisor  (den_s1),
		.in_side  ({neg_s1, keep_s1}),
		.out_valid(dv_valid),
		.quotient (dv_q),
		.out_side (dv_side)
	);

	// signed ndc value shifted by one (mirrored for y), so -1..1 lands in 0..2
	always_comb begin
		qs_d = N_W'(dv_q);
		n_d  = dv_side[1] ? -qs_d : qs_d;
		v_d  = IS_Y ? (N_W'(ONE_Q) - n_d) : (n_d + N_W'(ONE_Q));
	end

	always_ff @(posedge clk) begin
		keep_s2 <= dv_side[0];
		prod_s2 <= PW'(v_d) * PW'(SCREEN);
	end

	// floor halving, clamp, and zero for hidden edges
	assign half_d = prod_s2[PW-1:1];

	always_ff @(posedge clk) begin
		keep_s3 <= keep_s2;
		pix_s3  <= keep_s2 ? sat32(64'(half_d)) : 32'sd0;
	end

	assign out_valid = v_s3;
	assign out_keep  = keep_s3;
	assign pix       = pix_s3;

endmodule

// ===== rtl/core/wireframe_edge_transform_clip.sv =====
// top level: configuration registers, two vertex lanes, clip merge, four projections
// depends on wetc_pkg, wetc_lane, wetc_clip, wetc_proj and the assertion header
//
// Takes one edge per clock while busy is low: a transaction is taken at every rising
// edge with start high and busy low, and busy is only high for the first cycle after
// reset. Each edge comes out of the lanes, the clip merge and the projections as a
// one cycle done strobe with visible and the four pixel values; the receiver cannot
// stall, so results must be captured when done is high. Both dividers are pipelined,
// one quotient bit per stage: 31 stages for the clip fraction and 36 for the
// projection. Configuration writes take effect at once and belong in periods with
// no edge in flight.
`include "wireframe_edge_transform_clip_assert.svh"
module wireframe_edge_transform_clip import wetc_pkg::*; #(
	parameter int SCREEN_W = 800,
	parameter int SCREEN_H = 800
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] first_x,
	input  logic signed [31:0] first_y,
	input  logic signed [31:0] first_z,
	input  logic signed [31:0] second_x,
	input  logic signed [31:0] second_y,
	input  logic signed [31:0] second_z,
	input  logic               cfg_wr,
	input  logic [2:0]         cfg_addr,
	input  logic [31:0]        cfg_wdata,
	output logic               done,
	output logic               visible,
	output logic signed [31:0] start_px,
	output logic signed [31:0] start_py,
	output logic signed [31:0] end_px,
	output logic signed [31:0] end_py
);

	localparam int LAT = LANE_LAT + CLIP_LAT + PROJ_LAT;

	logic      busy_q;
	logic      accept;
	wetc_cfg_t cfg_q;
	wetc_vtx_t in_a, in_b, va, vb, ca, cb;
	logic      va_valid, vb_valid, c_valid, c_vis;
	logic [3:0] pv, pk;
	logic      pix_zero, proj_agree;

	// busy only covers the cycle after reset release
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy   = busy_q;
	assign accept = start && !busy_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spin_cos   <= 16'sd16384;
			cfg_q.spin_sin   <= 16'sd0;
			cfg_q.push_depth <= 32'sd196608;
			cfg_q.cam_x      <= 32'sd0;
			cfg_q.cam_y      <= 32'sd0;
			cfg_q.cam_z      <= 32'sd0;
			cfg_q.yaw_cos    <= 16'sd16384;
			cfg_q.yaw_sin    <= 16'sd0;
		end else if (cfg_wr) begin
			case (wetc_reg_t'(cfg_addr))
				REG_SPIN_COS:   cfg_q.spin_cos   <= cfg_wdata[15:0];
				REG_SPIN_SIN:   cfg_q.spin_sin   <= cfg_wdata[15:0];
				REG_PUSH_DEPTH: cfg_q.push_depth <= cfg_wdata;
				REG_CAM_X:      cfg_q.cam_x      <= cfg_wdata;
				REG_CAM_Y:      cfg_q.cam_y      <= cfg_wdata;
				REG_CAM_Z:      cfg_q.cam_z      <= cfg_wdata;
				REG_YAW_COS:    cfg_q.yaw_cos    <= cfg_wdata[15:0];
				REG_YAW_SIN:    cfg_q.yaw_sin    <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	assign in_a = '{x: first_x, y: first_y, z: first_z};
	assign in_b = '{x: second_x, y: second_y, z: second_z};

	// one lane per endpoint
	wetc_lane u_lane_a (
		.clk(clk), .arst_n(arst_n), .in_valid(accept), .in_vtx(in_a), .cfg(cfg_q),
		.out_valid(va_valid), .out_vtx(va)
	);

	wetc_lane u_lane_b (
		.clk(clk), .arst_n(arst_n), .in_valid(accept), .in_vtx(in_b), .cfg(cfg_q),
		.out_valid(vb_valid), .out_vtx(vb)
	);

	// merge the lanes: near plane clip
	wetc_clip u_clip (
		.clk(clk), .arst_n(arst_n), .in_valid(va_valid && vb_valid), .in_a(va), .in_b(vb),
		.out_valid(c_valid), .out_vis(c_vis), .out_a(ca), .out_b(cb)
	);

	// four projections side by side
	wetc_proj #(.SCREEN(SCREEN_W), .IS_Y(1'b0)) u_proj_ax (
		.clk(clk), .arst_n(arst_n), .in_valid(c_valid), .in_keep(c_vis),
		.coord(ca.x), .depth(ca.z), .out_valid(pv[0]), .out_keep(pk[0]), .pix(start_px)
	);

	wetc_proj #(.SCREEN(SCREEN_H), .IS_Y(1'b1)) u_proj_ay (
		.clk(clk), .arst_n(arst_n), .in_valid(c_valid), .in_keep(c_vis),
		.coord(ca.y), .depth(ca.z), .out_valid(pv[1]), .out_keep(pk[1]), .pix(start_py)
	);

	wetc_proj #(.SCREEN(SCREEN_W), .IS_Y(1'b0)) u_proj_bx (
		.clk(clk), .arst_n(arst_n), .in_valid(c_valid), .in_keep(c_vis),
		.coord(cb.x), .depth(cb.z), .out_valid(pv[2]), .out_keep(pk[2]), .pix(end_px)
	);

	wetc_proj #(.SCREEN(SCREEN_H), .IS_Y(1'b1)) u_proj_by (
		.clk(clk), .arst_n(arst_n), .in_valid(c_valid), .in_keep(c_vis),
		.coord(cb.y), .depth(cb.z), .out_valid(pv[3]), .out_keep(pk[3]), .pix(end_py)
	);

	assign done    = pv[0];
	assign visible = pk[0];

	// terms for the checks
	assign pix_zero = start_px == 32'sd0 && start_py == 32'sd0
		&& end_px == 32'sd0 && end_py == 32'sd0;
	assign proj_agree = pv[0] == pv[1] && pv[0] == pv[2] && pv[0] == pv[3]
		&& (!pv[0] || (pk[0] == pk[1] && pk[0] == pk[2] && pk[0] == pk[3]));

	// checks
	`WETC_ASSERT(a_fixed_latency, clk, arst_n, (start && !busy) |-> ##LAT done)
	`WETC_ASSERT(a_hidden_zero, clk, arst_n, (done && !visible) |-> pix_zero)
	`WETC_ASSERT(a_proj_aligned, clk, arst_n, proj_agree)
	`WETC_ASSERT(a_clip_in_front, clk, arst_n, (c_valid && c_vis) |-> (ca.z >= NEAR_Q && cb.z >= NEAR_Q))
	`WETC_ASSERT_NEVER(a_busy_once, clk, arst_n, $rose(busy))

endmodule

// ===== verif/wireframe_edge_transform_clip_tb.sv =====
// testbench for wireframe_edge_transform_clip: random and directed edges through a
// local fixed-point transform, clip and projection predictor; depends on wetc_pkg
module wireframe_edge_transform_clip_tb;
	import wetc_pkg::*;

	localparam int SCR_W = 800;
	localparam int SCR_H = 800;
	localparam longint NEAR = 6554;
	localparam longint ONE = 65536;
	localparam int DRAIN_CYC = 100;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic signed [31:0] ax, ay, az, bx, by, bz;
	} edge_item_t;

	typedef struct {
		logic               vis;
		logic signed [31:0] spx, spy, epx, epy;
	} pixel_pair_t;

	typedef struct {
		longint x, y, z;
	} pt_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [31:0] first_x = '0, first_y = '0, first_z = '0;
	logic signed [31:0] second_x = '0, second_y = '0, second_z = '0;
	logic cfg_wr = 1'b0;
	logic [2:0] cfg_addr = '0;
	logic [31:0] cfg_wdata = '0;
	logic done, visible;
	logic signed [31:0] start_px, start_py, end_px, end_py;

	// local copy of the configuration registers
	logic signed [15:0] m_spin_cos = 16'sd16384, m_spin_sin = 16'sd0;
	logic signed [31:0] m_push = 32'sd196608;
	logic signed [31:0] m_cam_x = '0, m_cam_y = '0, m_cam_z = '0;
	logic signed [15:0] m_yaw_cos = 16'sd16384, m_yaw_sin = 16'sd0;

	edge_item_t pending_edges[$];
	pixel_pair_t expected_pixels[$];
	int idle_pct = 0;
	bit took = 1'b0;
	int errors = 0;
	int n_edges = 0, n_visible = 0, n_hidden = 0;
	int cycles = 0;

	wireframe_edge_transform_clip #(.SCREEN_W(SCR_W), .SCREEN_H(SCR_H)) dut (.*);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("wireframe_edge_transform_clip_tb: done, errors");
			$finish;
		end
	end

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic pt_t turn_about_y(pt_t p, longint c, longint s);
		pt_t r;
		r.x = (p.x * c - p.z * s) >>> 14;
		r.y = p.y;
		r.z = (p.x * s + p.z * c) >>> 14;
		return r;
	endfunction

	function automatic pt_t model_to_view(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z);
		pt_t p;
		p.x = longint'(x);
		p.y = longint'(y);
		p.z = longint'(z);
		p = turn_about_y(p, longint'(m_spin_cos), longint'(m_spin_sin));
		p.z += longint'(m_push);
		p.x -= longint'(m_cam_x);
		p.y -= longint'(m_cam_y);
		p.z -= longint'(m_cam_z);
		p = turn_about_y(p, longint'(m_yaw_cos), longint'(m_yaw_sin));
		p.x = clamp32(p.x);
		p.y = clamp32(p.y);
		p.z = clamp32(p.z);
		return p;
	endfunction

	// move a point behind the near plane toward the other endpoint
	function automatic pt_t near_cut(pt_t m, pt_t o);
		longint num, den, t;
		num = NEAR - m.z;
		den = o.z - m.z;
		t = (den > 0) ? (num * (64'sd1 <<< 30)) / den : 0;
		m.x += ((o.x - m.x) * t) >>> 30;
		m.y += ((o.y - m.y) * t) >>> 30;
		m.z = NEAR;
		return m;
	endfunction

	function automatic void project(pt_t p, output logic signed [31:0] px,
			output logic signed [31:0] py);
		longint z, nx, ny;
		z = (p.z > 0) ? p.z : NEAR;
		nx = (p.x * ONE) / z;
		ny = (p.y * ONE) / z;
		px = 32'(clamp32(((nx + ONE) * SCR_W) >>> 1));
		py = 32'(clamp32(((ONE - ny) * SCR_H) >>> 1));
	endfunction

	function automatic pixel_pair_t edge_to_pixels(edge_item_t e);
		pixel_pair_t r;
		pt_t a, b;
		bit a_back, b_back;
		a = model_to_view(e.ax, e.ay, e.az);
		b = model_to_view(e.bx, e.by, e.bz);
		a_back = a.z < NEAR;
		b_back = b.z < NEAR;
		r = '{default: '0};
		if (!(a_back && b_back)) begin
			if (a_back) a = near_cut(a, b);
			else if (b_back) b = near_cut(b, a);
			project(a, r.spx, r.spy);
			project(b, r.epx, r.epy);
			r.vis = 1'b1;
		end
		return r;
	endfunction

	// monitor: accepted transactions, register writes and results
	always @(posedge clk) begin
		edge_item_t e;
		pixel_pair_t x;
		if (arst_n && cfg_wr) begin
			case (wetc_reg_t'(cfg_addr))
				REG_SPIN_COS: m_spin_cos = cfg_wdata[15:0];
				REG_SPIN_SIN: m_spin_sin = cfg_wdata[15:0];
				REG_PUSH_DEPTH: m_push = cfg_wdata;
				REG_CAM_X: m_cam_x = cfg_wdata;
				REG_CAM_Y: m_cam_y = cfg_wdata;
				REG_CAM_Z: m_cam_z = cfg_wdata;
				REG_YAW_COS: m_yaw_cos = cfg_wdata[15:0];
				REG_YAW_SIN: m_yaw_sin = cfg_wdata[15:0];
				default: ;
			endcase
		end
		if (arst_n && start && !busy) begin
			e = '{first_x, first_y, first_z, second_x, second_y, second_z};
			expected_pixels.push_back(edge_to_pixels(e));
			took = 1'b1;
		end
		if (arst_n && done) begin
			if (expected_pixels.size() == 0) begin
				$error("result with no transaction outstanding");
				errors++;
			end else begin
				x = expected_pixels.pop_front();
				n_edges++;
				if (x.vis) n_visible++; else n_hidden++;
				if (visible !== x.vis) begin
					$error("visible: expected %0d, got %0d", x.vis, visible);
					errors++;
				end
				if (start_px !== x.spx) begin
					$error("start_px: expected %0d, got %0d", x.spx, start_px);
					errors++;
				end
				if (start_py !== x.spy) begin
					$error("start_py: expected %0d, got %0d", x.spy, start_py);
					errors++;
				end
				if (end_px !== x.epx) begin
					$error("end_px: expected %0d, got %0d", x.epx, end_px);
					errors++;
				end
				if (end_py !== x.epy) begin
					$error("end_py: expected %0d, got %0d", x.epy, end_py);
					errors++;
				end
			end
		end
	end

	// driver: present the next edge at the falling edge
	always @(negedge clk) begin
		edge_item_t e;
		if (!start || took) begin
			took = 1'b0;
			if (arst_n && pending_edges.size() > 0 && $urandom_range(99) >= idle_pct) begin
				e = pending_edges.pop_front();
				start <= 1'b1;
				first_x <= e.ax;
				first_y <= e.ay;
				first_z <= e.az;
				second_x <= e.bx;
				second_y <= e.by;
				second_z <= e.bz;
			end else begin
				start <= 1'b0;
			end
		end
	end

	function automatic logic signed [31:0] rand_coord();
		if ($urandom_range(3) == 0) return $urandom;
		return int'($urandom_range(1310720)) - 655360;
	endfunction

	function automatic logic [15:0] rand_trig();
		case ($urandom_range(4))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'($urandom);
			default: return 16'(int'($urandom_range(32768)) - 16384);
		endcase
	endfunction

	function automatic logic [31:0] rand_offset();
		case ($urandom_range(5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom;
			default: return int'($urandom_range(524288)) - 262144;
		endcase
	endfunction

	task automatic write_reg(wetc_reg_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_wr <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wr <= 1'b0;
	endtask

	// hold off until every outstanding transaction has come back, then let the pipe empty
	task automatic drain();
		while (pending_edges.size() > 0 || start || expected_pixels.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic add_edge(logic signed [31:0] ax, ay, az, bx, by, bz);
		pending_edges.push_back('{ax, ay, az, bx, by, bz});
	endtask

	task automatic random_edges(int n);
		repeat (n) add_edge(rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), rand_coord(), rand_coord());
	endtask

	task automatic random_config();
		write_reg(REG_SPIN_COS, {16'h0, rand_trig()});
		write_reg(REG_SPIN_SIN, {16'h0, rand_trig()});
		write_reg(REG_PUSH_DEPTH, ($urandom_range(3) == 0) ? rand_offset()
			: 32'(int'($urandom_range(393216))));
		write_reg(REG_CAM_X, rand_offset());
		write_reg(REG_CAM_Y, rand_offset());
		write_reg(REG_CAM_Z, rand_offset());
		write_reg(REG_YAW_COS, {16'h0, rand_trig()});
		write_reg(REG_YAW_SIN, {16'h0, rand_trig()});
	endtask

	initial begin
		int pcts[4] = '{0, 61, 0, 15};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed edges under reset settings (view z = model z + 3.0)
		add_edge(0, 0, 0, 0, 0, 0);
		add_edge(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh80000000, 32'sh80000000, 32'sh80000000);
		add_edge(32'sh80000000, 32'sh7fffffff, 32'sh80000000,
			32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
		add_edge(65536, 65536, 0, -65536, -65536, 65536);
		// endpoint exactly on the near plane
		add_edge(65536, 65536, -190054, 0, 0, 0);
		add_edge(0, 0, 0, -65536, 65536, -190054);
		// both on the plane, and one just behind it
		add_edge(1, 2, -190054, 3, 4, -190054);
		add_edge(65536, 0, -190055, 0, 65536, 0);
		// both behind the plane
		add_edge(65536, 65536, -327680, -65536, 0, -262144);
		// one endpoint behind, in either order
		add_edge(131072, -131072, -393216, 0, 0, 131072);
		add_edge(0, 0, 655360, -131072, 262144, -655360);
		// huge coordinates close to the plane saturate pixels
		add_edge(32'sh7fffffff, 32'sh80000000, -190054, 32'sh80000000, 32'sh7fffffff, -190054);
		add_edge(32'sh40000000, 32'sh40000000, -180000, 0, 0, 32'sh7fffffff);
		drain();

		// extreme settings
		write_reg(REG_SPIN_COS, 32'hffffc000);
		write_reg(REG_SPIN_SIN, 32'h00004000);
		write_reg(REG_PUSH_DEPTH, 32'h7fffffff);
		write_reg(REG_CAM_X, 32'h80000000);
		write_reg(REG_CAM_Y, 32'h7fffffff);
		write_reg(REG_CAM_Z, 32'h80000000);
		write_reg(REG_YAW_COS, 32'h00000000);
		write_reg(REG_YAW_SIN, 32'hffffc000);
		add_edge(0, 0, 0, 65536, 65536, 65536);
		add_edge(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0, 0, 0);
		random_edges(30);
		drain();

		// random phases: reset settings every third phase, random settings otherwise
		for (int ph = 0; ph < 12; ph++) begin
			idle_pct = pcts[ph % 4];
			if (ph % 3 == 0) begin
				write_reg(REG_SPIN_COS, 32'h4000);
				write_reg(REG_SPIN_SIN, 32'h0);
				write_reg(REG_PUSH_DEPTH, 32'd196608);
				write_reg(REG_CAM_X, 32'h0);
				write_reg(REG_CAM_Y, 32'h0);
				write_reg(REG_CAM_Z, 32'h0);
				write_reg(REG_YAW_COS, 32'h4000);
				write_reg(REG_YAW_SIN, 32'h0);
			end else begin
				random_config();
			end
			random_edges(64);
			drain();
		end

		$display("covered %0d edges over 14 register settings: %0d visible, %0d fully behind",
			n_edges, n_visible, n_hidden);
		if (errors == 0 && expected_pixels.size() == 0) begin
			$display("wireframe_edge_transform_clip_tb: done, clean");
		end else begin
			$display("wireframe_edge_transform_clip_tb: done, errors");
		end
		$finish;
	end

endmodule
